// ----- rtl/core/imm_pkg.sv -----
// Package for the integer matrix multiply: sizes, opcodes, register indexes.
`default_nettype none
package imm_pkg;
    localparam int MaxDim    = 8;
    localparam int IdxW      = 3;
    localparam int DimW      = 4;
    localparam int ElemW     = 16;
    localparam int ProdW     = 35;
    localparam int AddrW     = 6;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_COLS_A = 2'd1;
    localparam logic [1:0] REG_COLS_B = 2'd2;

    // Control word handed along the cell chain with each A operand.
    typedef struct packed {
        logic            vld;
        logic            first;
        logic            fin;
        logic            last;
        logic [IdxW-1:0] r;
    } imm_ctl_t;

    function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
        logic [DimW-1:0] res;
        res = d;
        if (d == '0) res = DimW'(1);
        else if (d > DimW'(MaxDim)) res = DimW'(MaxDim);
        return res;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/imm_cell.sv -----
// One MAC cell: owns one column of B and one output column, passes A along.
`default_nettype none
module imm_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              b_we,
    input  wire logic [imm_pkg::IdxW-1:0]          b_row,
    input  wire logic signed [imm_pkg::ElemW-1:0]  b_val,
    input  wire logic [imm_pkg::IdxW-1:0]          k_in,
    input  wire imm_pkg::imm_ctl_t                 ctl_in,
    input  wire logic signed [imm_pkg::ElemW-1:0]  a_in,
    output imm_pkg::imm_ctl_t                      ctl_out,
    output logic [imm_pkg::IdxW-1:0]               k_out,
    output logic signed [imm_pkg::ElemW-1:0]       a_out,
    output logic                                   done,
    output logic signed [imm_pkg::ProdW-1:0]       sum
);
    logic signed [imm_pkg::ElemW-1:0] bcol [imm_pkg::MaxDim];
    logic signed [imm_pkg::ElemW-1:0] b_rd_reg;
    logic signed [imm_pkg::ElemW-1:0] a_reg;
    imm_pkg::imm_ctl_t                ctl_reg;
    logic signed [2*imm_pkg::ElemW-1:0] mul_reg;
    imm_pkg::imm_ctl_t                mctl_reg;
    logic signed [imm_pkg::ProdW-1:0] acc_reg, acc_next;
    logic                             done_reg;
    logic [imm_pkg::IdxW-1:0]         k_reg;

    always_ff @(posedge clk)
    begin
        if (b_we)
            bcol[b_row] <= b_val;
        b_rd_reg <= bcol[k_in];
        a_reg    <= a_in;
        k_reg    <= k_in;
        mul_reg  <= a_reg * b_rd_reg;
    end

    always_comb
    begin
        acc_next = mctl_reg.first ? imm_pkg::ProdW'(mul_reg)
                                  : acc_reg + imm_pkg::ProdW'(mul_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            mctl_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl_in;
            mctl_reg <= ctl_reg;
            done_reg <= mctl_reg.vld && mctl_reg.fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mctl_reg.vld)
            acc_reg <= acc_next;
    end

    assign ctl_out = ctl_reg;
    assign k_out   = k_reg;
    assign a_out   = a_reg;
    assign done    = done_reg;
    assign sum     = acc_reg;
endmodule
`default_nettype wire

// ----- rtl/core/integer_matrix_multiply.sv -----
// Top level: A store, sequencer, chain of MAC cells and result drain.
//
//  channel  signals                                dir  handshake
//  cmd      start opcode row col value             in   start & !busy
//  result   out_row out_col product last           out  strobe, one cycle
//  config   cfg_we cfg_index cfg_data              in   cfg_we
//
// A load (or an unused opcode) leaves busy low.
// A compute runs one C row at a time: the A row is streamed down the
// cell chain, the last cell finishes its sums, then the row is drained
// as back-to-back words; the next row starts after the last word. busy
// stays high until the last row's final word has been sent.
// Reset clears control only; stores are undefined until written.
`default_nettype none
module integer_matrix_multiply (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [1:0]   opcode,
    input  wire logic [2:0]   row,
    input  wire logic [2:0]   col,
    input  wire logic signed [15:0] value,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [3:0]   cfg_data,
    output logic              strobe,
    output logic [2:0]        out_row,
    output logic [2:0]        out_col,
    output logic signed [34:0] product,
    output logic              last
);
    localparam int N = imm_pkg::MaxDim;
    localparam int IW = imm_pkg::IdxW;
    localparam int DW = imm_pkg::DimW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FEED  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [DW-1:0] rows_reg, cola_reg, colb_reg;
    logic [1:0]    st_reg, st_next;
    logic [IW-1:0] r_reg, r_next, k_reg, k_next;
    logic [DW-1:0] m, n, q;
    logic          acc_cmd;

    // A store: one word per element, read once a cycle while feeding.
    logic signed [15:0] mem_a [N*N];
    logic signed [15:0] a_rd_reg;
    imm_pkg::imm_ctl_t  feed_ctl_reg, feed_ctl;
    logic [IW-1:0]      feed_k_reg;

    imm_pkg::imm_ctl_t  ctl_c [N+1];
    logic [IW-1:0]      k_c   [N+1];
    logic signed [15:0] a_c   [N+1];
    logic               done_c [N];
    logic signed [34:0] sum_c  [N];

    // Row tag trailing the last cell's MAC pipe.
    imm_pkg::imm_ctl_t  fin_d1_reg, fin_d2_reg;
    logic               row_rdy;

    // Drain buffer: snapshot of one output row.
    logic signed [34:0] row_buf_reg [N];
    logic [IW-1:0]      row_id_reg;
    logic               row_last_reg;
    logic               drain_reg;
    logic [IW-1:0]      dc_reg;
    logic               row_end_reg;
    logic               strobe_reg, last_reg;
    logic [IW-1:0]      orow_reg, ocol_reg;
    logic signed [34:0] prod_reg;

    assign m = imm_pkg::clamp_dim(rows_reg);
    assign n = imm_pkg::clamp_dim(cola_reg);
    assign q = imm_pkg::clamp_dim(colb_reg);
    assign acc_cmd = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DW'(8);
            cola_reg <= DW'(8);
            colb_reg <= DW'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                imm_pkg::REG_ROWS_A: rows_reg <= cfg_data;
                imm_pkg::REG_COLS_A: cola_reg <= cfg_data;
                imm_pkg::REG_COLS_B: colb_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_cmd && opcode == imm_pkg::OP_LOAD_A)
            mem_a[{row, col}] <= value;
        a_rd_reg <= mem_a[{r_reg, k_reg}];
    end

    // Sequencer: stream row r of A, k = 0..n-1, one element a cycle, then
    // hold until that row has fully drained before feeding the next one.
    always_comb
    begin
        st_next = st_reg;
        r_next  = r_reg;
        k_next  = k_reg;
        feed_ctl = '0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (acc_cmd && opcode == imm_pkg::OP_COMPUTE)
                begin
                    st_next = ST_FEED;
                    r_next  = '0;
                    k_next  = '0;
                end
            end
            ST_FEED:
            begin
                feed_ctl.vld   = 1'b1;
                feed_ctl.first = (k_reg == '0);
                feed_ctl.fin   = ({1'b0, k_reg} == n - DW'(1));
                feed_ctl.last  = ({1'b0, r_reg} == m - DW'(1));
                feed_ctl.r     = r_reg;
                if (feed_ctl.fin)
                begin
                    k_next  = '0;
                    r_next  = r_reg + IW'(1);
                    st_next = ST_DRAIN;
                end
                else
                    k_next = k_reg + IW'(1);
            end
            ST_DRAIN:
            begin
                // row_end_reg marks the cycle of the row's final word
                if (row_end_reg)
                    st_next = row_last_reg ? ST_IDLE : ST_FEED;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            r_reg        <= '0;
            k_reg        <= '0;
            feed_ctl_reg <= '0;
        end
        else
        begin
            st_reg       <= st_next;
            r_reg        <= r_next;
            k_reg        <= k_next;
            feed_ctl_reg <= feed_ctl;
        end
    end

    always_ff @(posedge clk)
        feed_k_reg <= k_reg;

    assign ctl_c[0] = feed_ctl_reg;
    assign k_c[0]   = feed_k_reg;
    assign a_c[0]   = a_rd_reg;

    // The A element is registered in each cell as it flows down the chain;
    // each cell multiplies it with its own B column and accumulates one C column.
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        imm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .b_we    (acc_cmd && opcode == imm_pkg::OP_LOAD_B && col == IW'(i)),
            .b_row   (row),
            .b_val   (value),
            .k_in    (k_c[i]),
            .ctl_in  (ctl_c[i]),
            .a_in    (a_c[i]),
            .ctl_out (ctl_c[i+1]),
            .k_out   (k_c[i+1]),
            .a_out   (a_c[i+1]),
            .done    (done_c[i]),
            .sum     (sum_c[i])
        );
    end

    // ctl_c[N] is the last cell's stage-1 ctl; its done follows through the
    // mctl_reg and done_reg registers. Only one row is in the chain at a time,
    // so every cell's sum holds its final value when the last cell is done.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_d1_reg <= '0;
            fin_d2_reg <= '0;
        end
        else
        begin
            fin_d1_reg <= ctl_c[N];
            fin_d2_reg <= fin_d1_reg;
        end
    end

    assign row_rdy = done_c[N-1];

    always_ff @(posedge clk)
    begin
        if (row_rdy)
        begin
            for (int i = 0; i < N; i++)
                row_buf_reg[i] <= sum_c[i];
            row_id_reg   <= fin_d2_reg.r;
            row_last_reg <= fin_d2_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg   <= 1'b0;
            dc_reg      <= '0;
            strobe_reg  <= 1'b0;
            row_end_reg <= 1'b0;
        end
        else
        begin
            strobe_reg  <= drain_reg;
            row_end_reg <= drain_reg && ({1'b0, dc_reg} == q - DW'(1));
            if (row_rdy)
            begin
                drain_reg <= 1'b1;
                dc_reg    <= '0;
            end
            else if (drain_reg)
            begin
                if ({1'b0, dc_reg} == q - DW'(1))
                    drain_reg <= 1'b0;
                dc_reg <= dc_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        orow_reg <= row_id_reg;
        ocol_reg <= dc_reg;
        prod_reg <= row_buf_reg[dc_reg];
        last_reg <= row_last_reg && ({1'b0, dc_reg} == q - DW'(1));
    end

    assign busy    = (st_reg != ST_IDLE);
    assign strobe  = strobe_reg;
    assign out_row = orow_reg;
    assign out_col = ocol_reg;
    assign product = prod_reg;
    assign last    = strobe_reg && last_reg;

`ifndef NO_ASSERTIONS
    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe) else $error("last without strobe");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !strobe) else $error("result while idle");
    a_drain_state: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> (st_reg == ST_DRAIN)) else $error("drain outside row wait");
`endif
endmodule
`default_nettype wire
